>>> hdl/u8t_pkg.sv
`default_nettype none
package u8t_pkg;

    localparam int unsigned C_DATA_BITS     = 8;
    localparam int unsigned C_TX_FRAME_BITS = 9;
    localparam int unsigned C_PERIOD_W      = 16;
    localparam int unsigned C_RX_CD_W       = C_PERIOD_W + 1;
    localparam int unsigned C_IDX_W         = 4;

    localparam logic [C_PERIOD_W-1:0] C_PERIOD_RESET = 16'd434;

    // register index taken from paddr[2]
    localparam logic C_REG_BIT_PERIOD = 1'b0;

    typedef struct packed {
        logic                   valid;
        logic [C_DATA_BITS-1:0] data;
    } t_rx_res;

    typedef struct packed {
        logic line;
        logic taken;
        logic busy;
    } t_tx_res;

endpackage
`default_nettype wire

>>> hdl/u8t_rx.sv
`default_nettype none
module u8t_rx
    import u8t_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_step,
    input  wire logic [C_PERIOD_W-1:0] i_bit_period,
    input  wire logic                  i_rx_line,
    output t_rx_res                    o_res
);

    logic                   r_prev, n_prev;
    logic                   r_active, n_active;
    logic [C_IDX_W-1:0]     r_idx, n_idx;
    logic [C_DATA_BITS-1:0] r_shift, n_shift;
    logic [C_RX_CD_W-1:0]   r_cd, n_cd;

    always_comb begin
        n_prev   = i_rx_line;
        n_active = r_active;
        n_idx    = r_idx;
        n_shift  = r_shift;
        n_cd     = r_cd;
        o_res    = '0;
        if (!r_active) begin
            if (r_prev && !i_rx_line) begin
                n_active = 1'b1;
                n_idx    = '0;
                n_shift  = '0;
                // first sample lands in the middle of bit 0
                n_cd     = {1'b0, i_bit_period} + C_RX_CD_W'(i_bit_period >> 1);
            end
        end else if (r_cd > C_RX_CD_W'(1)) begin
            n_cd = r_cd - C_RX_CD_W'(1);
        end else if (r_idx < C_IDX_W'(C_DATA_BITS)) begin
            // lsb first: shift in from the top
            n_shift = {i_rx_line, r_shift[C_DATA_BITS-1:1]};
            n_idx   = r_idx + C_IDX_W'(1);
            n_cd    = {1'b0, i_bit_period};
        end else begin
            n_active = 1'b0;
            if (i_rx_line) begin
                o_res.valid = 1'b1;
                o_res.data  = r_shift;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev   <= 1'b1;
            r_active <= 1'b0;
            r_idx    <= '0;
            r_cd     <= '0;
        end else if (i_step) begin
            r_prev   <= n_prev;
            r_active <= n_active;
            r_idx    <= n_idx;
            r_cd     <= n_cd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_step) begin
            r_shift <= n_shift;
        end
    end

endmodule
`default_nettype wire

>>> hdl/u8t_tx.sv
`default_nettype none
module u8t_tx
    import u8t_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_step,
    input  wire logic [C_PERIOD_W-1:0]  i_bit_period,
    input  wire logic                   i_tx_valid,
    input  wire logic [C_DATA_BITS-1:0] i_tx_data,
    output t_tx_res                     o_res
);

    logic                       r_active, n_active;
    logic [C_TX_FRAME_BITS-1:0] r_shift, n_shift;
    logic [C_IDX_W-1:0]         r_left, n_left;
    logic [C_PERIOD_W-1:0]      r_cd, n_cd;
    logic                       r_level, n_level;
    logic                       load;

    always_comb begin
        n_active = r_active;
        n_shift  = r_shift;
        n_left   = r_left;
        n_cd     = r_cd;
        n_level  = r_level;
        load     = 1'b0;
        if (!r_active) begin
            if (i_tx_valid) begin
                load     = 1'b1;
                n_active = 1'b1;
            end
        end else if (r_cd > C_PERIOD_W'(1)) begin
            n_cd = r_cd - C_PERIOD_W'(1);
        end else if (r_left != '0) begin
            n_level = r_shift[0];
            n_shift = r_shift >> 1;
            n_left  = r_left - C_IDX_W'(1);
            n_cd    = i_bit_period;
        end else if (i_tx_valid) begin
            // end of stop bit, next byte follows back to back
            load = 1'b1;
        end else begin
            n_active = 1'b0;
            n_level  = 1'b1;
        end
        if (load) begin
            n_level = 1'b0;
            n_shift = {1'b1, i_tx_data};
            n_left  = C_IDX_W'(C_TX_FRAME_BITS);
            n_cd    = i_bit_period;
        end
        o_res.line  = n_level;
        o_res.taken = load;
        o_res.busy  = n_active;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_left   <= '0;
            r_cd     <= '0;
            r_level  <= 1'b1;
        end else if (i_step) begin
            r_active <= n_active;
            r_left   <= n_left;
            r_cd     <= n_cd;
            r_level  <= n_level;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_step) begin
            r_shift <= n_shift;
        end
    end

endmodule
`default_nettype wire

>>> hdl/uart_8n1_transceiver_unit.sv
`default_nettype none
// 8n1 uart receiver and transmitter driven by one input beat per clock tick. each
// beat carries the receive pin level and an optional transmit byte; each beat
// yields exactly one result beat with the transmit pin level, taken/busy flags
// and any byte received with a good stop bit. a beat is accepted every cycle
// unless o_in_stall is high; it is held in the input register until it moves on,
// the receiver and transmitter update in a single pass, and the result is registered
// in the output register. a stalled consumer holds the output register and, once
// the input register is full, the producer. bit_period (apb address 0, reset 434)
// counts ticks per serial bit; write it only while no beats are in flight.
module uart_8n1_transceiver_unit
    import u8t_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   psel,
    input  wire logic                   penable,
    input  wire logic                   pwrite,
    input  wire logic [2:0]             paddr,
    input  wire logic [31:0]            pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    input  wire logic                   i_in_valid,
    output logic                        o_in_stall,
    input  wire logic                   i_rx_line,
    input  wire logic                   i_tx_valid,
    input  wire logic [C_DATA_BITS-1:0] i_tx_data,
    output logic                        o_out_valid,
    input  wire logic                   i_out_stall,
    output logic                        o_tx_line,
    output logic                        o_tx_taken,
    output logic                        o_tx_busy,
    output logic                        o_rx_valid,
    output logic [C_DATA_BITS-1:0]      o_rx_data
);

    logic [C_PERIOD_W-1:0]  r_bit_period;
    logic                   r_in_valid;
    logic                   r_rx_line;
    logic                   r_tx_valid;
    logic [C_DATA_BITS-1:0] r_tx_data;
    logic                   r_out_valid;
    t_rx_res                r_rx_res;
    t_tx_res                r_tx_res;
    t_rx_res                rx_res;
    t_tx_res                tx_res;
    logic                   step;
    logic                   in_accept;
    logic                   cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == C_REG_BIT_PERIOD);
    assign prdata = (paddr[2] == C_REG_BIT_PERIOD) ? {16'd0, r_bit_period} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bit_period <= C_PERIOD_RESET;
        end else if (cfg_wr) begin
            r_bit_period <= pwdata[C_PERIOD_W-1:0];
        end
    end

    // the input beat moves on when the output register is free or draining
    assign step       = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !step;
    assign in_accept  = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_accept) begin
            r_in_valid <= 1'b1;
        end else if (step) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_rx_line  <= i_rx_line;
            r_tx_valid <= i_tx_valid;
            r_tx_data  <= i_tx_data;
        end
    end

    u8t_rx u_rx (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (step),
        .i_bit_period (r_bit_period),
        .i_rx_line    (r_rx_line),
        .o_res        (rx_res)
    );

    u8t_tx u_tx (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (step),
        .i_bit_period (r_bit_period),
        .i_tx_valid   (r_tx_valid),
        .i_tx_data    (r_tx_data),
        .o_res        (tx_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_rx_res <= rx_res;
            r_tx_res <= tx_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_tx_line   = r_tx_res.line;
    assign o_tx_taken  = r_tx_res.taken;
    assign o_tx_busy   = r_tx_res.busy;
    assign o_rx_valid  = r_rx_res.valid;
    assign o_rx_data   = r_rx_res.data;

endmodule
`default_nettype wire

>>> hdl/u8t_checker.sv
`default_nettype none
module u8t_checker
    import u8t_pkg::*;
(
    input wire logic                   i_clk,
    input wire logic                   i_rst_n,
    input wire logic                   o_out_valid,
    input wire logic                   i_out_stall,
    input wire logic                   o_tx_line,
    input wire logic                   o_tx_taken,
    input wire logic                   o_tx_busy,
    input wire logic                   o_rx_valid,
    input wire logic [C_DATA_BITS-1:0] o_rx_data
);

    // no result beat straight out of reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result beat right after reset");

    // a taken byte starts its frame with the start bit
    a_taken_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_tx_taken |-> o_tx_busy && !o_tx_line)
        else $error("taken byte without start bit");

    // idle transmitter holds the line high
    a_idle_high: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_tx_busy |-> o_tx_line)
        else $error("idle transmitter not high");

    // no stale byte when nothing was received
    a_rx_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_rx_valid |-> o_rx_data == '0)
        else $error("rx data without rx valid");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_tx_line)
            && $stable(o_rx_data))
        else $error("stalled beat changed");

endmodule

bind uart_8n1_transceiver_unit u8t_checker u_u8t_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_tx_line   (o_tx_line),
    .o_tx_taken  (o_tx_taken),
    .o_tx_busy   (o_tx_busy),
    .o_rx_valid  (o_rx_valid),
    .o_rx_data   (o_rx_data)
);
`default_nettype wire
